// File: hw/rtl/i2cbl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbl_pkg
// Shared types and constants for the I2C bootloader host sequencer: opcodes,
// phases, result kinds, status codes, run descriptors and register map.
// ----------------------------------------------------------------------------
package i2cbl_pkg;

  // largest payload a write may carry
  localparam int unsigned MAX_PAYLOAD = 256;

  // reply bytes from the target
  localparam logic [7:0] BYTE_ACK  = 8'h79;
  localparam logic [7:0] BYTE_NACK = 8'h1F;

  // command bytes, sent with their complement
  localparam logic [7:0] CMD_GETID = 8'h02;
  localparam logic [7:0] CMD_ERASE = 8'h44;
  localparam logic [7:0] CMD_WRITE = 8'h31;
  localparam logic [7:0] CMD_GO    = 8'h21;

  // special mass erase frame: ff ff 00
  localparam logic [7:0] ERASE_FILL = 8'hFF;
  localparam logic [7:0] ERASE_END  = 8'h00;

  // register reset values, in ms
  localparam logic [15:0] RST_CMD_ACK   = 16'd800;
  localparam logic [15:0] RST_ADDR_ACK  = 16'd1500;
  localparam logic [15:0] RST_DATA_ACK  = 16'd5000;
  localparam logic [15:0] RST_ERASE_ACK = 16'd30000;
  localparam logic [15:0] RST_GO_ACK    = 16'd500;

  typedef enum logic [2:0] {
    OP_GETID,
    OP_ERASE,
    OP_WRITE,
    OP_GO,
    OP_PAYLOAD,
    OP_TARGET,
    OP_TICK,
    OP_FAULT
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_CMD_ACK,
    PH_ADDR_ACK,
    PH_PAYLOAD,
    PH_DATA_ACK,
    PH_ERASE_ACK,
    PH_GO_ACK,
    PH_ID_REPLY
  } phase_t;

  typedef enum logic [1:0] {
    KIND_TX,
    KIND_READ,
    KIND_DONE
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_NACK,
    ST_TIMEOUT,
    ST_BAD_RESP,
    ST_BUS_FAULT,
    ST_BAD_REQ
  } status_t;

  // shape of the result run that one item causes
  typedef enum logic [2:0] {
    RUN_CMD,          // cmd, ~cmd (end), read
    RUN_ERASE,        // ff, ff, 00 (end), read
    RUN_ADDR,         // four address bytes, xor (end), read
    RUN_TX,           // one byte, no frame end
    RUN_PAYLOAD_END,  // last payload byte, xor (end), read
    RUN_READ,         // one read request
    RUN_DONE          // completion
  } run_t;

  typedef enum logic [2:0] {
    REG_CMD_ACK,
    REG_ADDR_ACK,
    REG_DATA_ACK,
    REG_ERASE_ACK,
    REG_GO_ACK
  } reg_idx_t;

  typedef struct packed {
    run_t        run;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [31:0] addr;
    status_t     status;
    logic [15:0] id;
  } run_desc_t;

  typedef struct packed {
    logic [15:0] cmd_ack;
    logic [15:0] addr_ack;
    logic [15:0] data_ack;
    logic [15:0] erase_ack;
    logic [15:0] go_ack;
  } ack_limits_t;

endpackage

// File: hw/rtl/i2cbl_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbl_cfg_regs
// APB-style register file holding the five acknowledge time limits.
// ----------------------------------------------------------------------------
module i2cbl_cfg_regs (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [4:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  output i2cbl_pkg::ack_limits_t  limits
);
  import i2cbl_pkg::*;

  ack_limits_t limits_r;
  ack_limits_t limits_nxt;
  reg_idx_t    idx;
  logic        wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite;
  assign limits = limits_r;

  always_comb begin
    limits_nxt = limits_r;
    if (wr_en) begin
      unique case (idx)
        REG_CMD_ACK:   limits_nxt.cmd_ack   = pwdata[15:0];
        REG_ADDR_ACK:  limits_nxt.addr_ack  = pwdata[15:0];
        REG_DATA_ACK:  limits_nxt.data_ack  = pwdata[15:0];
        REG_ERASE_ACK: limits_nxt.erase_ack = pwdata[15:0];
        REG_GO_ACK:    limits_nxt.go_ack    = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CMD_ACK:   prdata = {16'd0, limits_r.cmd_ack};
      REG_ADDR_ACK:  prdata = {16'd0, limits_r.addr_ack};
      REG_DATA_ACK:  prdata = {16'd0, limits_r.data_ack};
      REG_ERASE_ACK: prdata = {16'd0, limits_r.erase_ack};
      REG_GO_ACK:    prdata = {16'd0, limits_r.go_ack};
      default:       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limits_r.cmd_ack   <= RST_CMD_ACK;
      limits_r.addr_ack  <= RST_ADDR_ACK;
      limits_r.data_ack  <= RST_DATA_ACK;
      limits_r.erase_ack <= RST_ERASE_ACK;
      limits_r.go_ack    <= RST_GO_ACK;
    end else begin
      limits_r <= limits_nxt;
    end
  end

endmodule

// File: hw/rtl/i2cbl_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbl_front
// Protocol sequencer: classifies each item against the current phase, updates
// the exchange state and issues one run descriptor per item that has results.
// ----------------------------------------------------------------------------
module i2cbl_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    item_valid,
  input  logic [2:0]              opcode,
  input  logic [31:0]             target_address,
  input  logic [8:0]              payload_length,
  input  logic [7:0]              byte_value,
  input  i2cbl_pkg::ack_limits_t  limits,
  output logic                    desc_push,
  output i2cbl_pkg::run_desc_t    desc
);
  import i2cbl_pkg::*;

  phase_t      phase_r,       phase_nxt;
  op_t         operation_r,   operation_nxt;
  logic [31:0] held_address_r, held_address_nxt;
  logic [8:0]  bytes_left_r,  bytes_left_nxt;
  logic [7:0]  running_xor_r, running_xor_nxt;
  logic [15:0] elapsed_r,     elapsed_nxt;
  logic [2:0]  reply_index_r, reply_index_nxt;
  logic [15:0] id_value_r,    id_value_nxt;

  op_t         op;
  logic [7:0]  xor_mix;
  logic [8:0]  left;
  logic [15:0] limit;
  logic        in_ack_wait;

  assign op      = op_t'(opcode);
  assign xor_mix = running_xor_r ^ byte_value;
  assign left    = bytes_left_r - {8'd0, (bytes_left_r != 9'd0)};

  assign in_ack_wait = (phase_r == PH_CMD_ACK) || (phase_r == PH_ADDR_ACK) ||
                       (phase_r == PH_DATA_ACK) || (phase_r == PH_ERASE_ACK) ||
                       (phase_r == PH_GO_ACK);

  always_comb begin
    unique case (phase_r)
      PH_CMD_ACK:   limit = limits.cmd_ack;
      PH_ADDR_ACK:  limit = limits.addr_ack;
      PH_DATA_ACK:  limit = limits.data_ack;
      PH_ERASE_ACK: limit = limits.erase_ack;
      default:      limit = limits.go_ack;
    endcase
  end

  always_comb begin
    phase_nxt        = phase_r;
    operation_nxt    = operation_r;
    held_address_nxt = held_address_r;
    bytes_left_nxt   = bytes_left_r;
    running_xor_nxt  = running_xor_r;
    elapsed_nxt      = elapsed_r;
    reply_index_nxt  = reply_index_r;
    id_value_nxt     = id_value_r;
    desc_push        = 1'b0;
    desc             = '0;
    desc.run         = RUN_READ;
    desc.status      = ST_OK;

    if (item_valid) begin
      unique case (op)
        OP_GETID, OP_ERASE, OP_WRITE, OP_GO: begin
          if (phase_r == PH_IDLE) begin
            id_value_nxt     = 16'd0;
            operation_nxt    = op;
            held_address_nxt = target_address;
            desc_push        = 1'b1;
            if (op == OP_WRITE && (payload_length == 9'd0 ||
                payload_length > 9'(MAX_PAYLOAD))) begin
              desc.run    = RUN_DONE;
              desc.status = ST_BAD_REQ;
            end else begin
              if (op == OP_WRITE) begin
                bytes_left_nxt  = payload_length;
                running_xor_nxt = payload_length[7:0] - 8'd1;
              end
              desc.run = RUN_CMD;
              unique case (op)
                OP_GETID: desc.byte0 = CMD_GETID;
                OP_ERASE: desc.byte0 = CMD_ERASE;
                OP_WRITE: desc.byte0 = CMD_WRITE;
                default:  desc.byte0 = CMD_GO;
              endcase
              phase_nxt   = PH_CMD_ACK;
              elapsed_nxt = 16'd0;
            end
          end
        end

        OP_PAYLOAD: begin
          if (phase_r == PH_PAYLOAD) begin
            desc_push       = 1'b1;
            running_xor_nxt = xor_mix;
            bytes_left_nxt  = left;
            desc.byte0      = byte_value;
            if (left == 9'd0) begin
              desc.run    = RUN_PAYLOAD_END;
              desc.byte1  = xor_mix;
              phase_nxt   = PH_DATA_ACK;
              elapsed_nxt = 16'd0;
            end else begin
              desc.run = RUN_TX;
            end
          end
        end

        OP_TARGET: begin
          if (phase_r != PH_IDLE && phase_r != PH_PAYLOAD) begin
            desc_push = 1'b1;
            desc.id   = id_value_r;
            if (phase_r == PH_ID_REPLY) begin
              if (reply_index_r == 3'd0 && byte_value != BYTE_ACK) begin
                desc.run    = RUN_DONE;
                desc.status = ST_BAD_RESP;
                phase_nxt   = PH_IDLE;
              end else if (reply_index_r >= 3'd4) begin
                desc.run  = RUN_DONE;
                phase_nxt = PH_IDLE;
              end else begin
                if (reply_index_r == 3'd2) begin
                  id_value_nxt[15:8] = byte_value;
                end
                if (reply_index_r == 3'd3) begin
                  id_value_nxt[7:0] = byte_value;
                end
                reply_index_nxt = reply_index_r + 3'd1;
                desc.run        = RUN_READ;
              end
            end else if (byte_value == BYTE_ACK) begin
              if (phase_r == PH_CMD_ACK) begin
                elapsed_nxt = 16'd0;
                unique case (operation_r)
                  OP_GETID: begin
                    reply_index_nxt = 3'd0;
                    phase_nxt       = PH_ID_REPLY;
                    desc.run        = RUN_READ;
                  end
                  OP_ERASE: begin
                    desc.run  = RUN_ERASE;
                    phase_nxt = PH_ERASE_ACK;
                  end
                  OP_WRITE: begin
                    desc.run  = RUN_ADDR;
                    desc.addr = held_address_r;
                    phase_nxt = PH_ADDR_ACK;
                  end
                  default: begin
                    desc.run  = RUN_ADDR;
                    desc.addr = held_address_r;
                    phase_nxt = PH_GO_ACK;
                  end
                endcase
              end else if (phase_r == PH_ADDR_ACK) begin
                desc.run   = RUN_TX;
                desc.byte0 = running_xor_r;
                phase_nxt  = PH_PAYLOAD;
              end else begin
                desc.run  = RUN_DONE;
                phase_nxt = PH_IDLE;
              end
            end else if (byte_value == BYTE_NACK) begin
              desc.run    = RUN_DONE;
              desc.status = ST_NACK;
              phase_nxt   = PH_IDLE;
            end else if (elapsed_r >= limit) begin
              desc.run    = RUN_DONE;
              desc.status = ST_TIMEOUT;
              phase_nxt   = PH_IDLE;
            end else begin
              desc.run = RUN_READ;
            end
          end
        end

        OP_TICK: begin
          if (in_ack_wait && elapsed_r != 16'hFFFF) begin
            elapsed_nxt = elapsed_r + 16'd1;
          end
        end

        OP_FAULT: begin
          if (phase_r != PH_IDLE) begin
            desc_push   = 1'b1;
            desc.run    = RUN_DONE;
            desc.status = ST_BUS_FAULT;
            desc.id     = id_value_r;
            phase_nxt   = PH_IDLE;
          end
        end

        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      operation_r    <= OP_GETID;
      held_address_r <= 32'd0;
      bytes_left_r   <= 9'd0;
      running_xor_r  <= 8'd0;
      elapsed_r      <= 16'd0;
      reply_index_r  <= 3'd0;
      id_value_r     <= 16'd0;
    end else begin
      phase_r        <= phase_nxt;
      operation_r    <= operation_nxt;
      held_address_r <= held_address_nxt;
      bytes_left_r   <= bytes_left_nxt;
      running_xor_r  <= running_xor_nxt;
      elapsed_r      <= elapsed_nxt;
      reply_index_r  <= reply_index_nxt;
      id_value_r     <= id_value_nxt;
    end
  end

endmodule

// File: hw/rtl/i2cbl_run_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbl_run_fifo
// Short queue of run descriptors between the sequencer and the result stage.
// ----------------------------------------------------------------------------
module i2cbl_run_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  i2cbl_pkg::run_desc_t  wr_data,
  output logic                  full,
  input  logic                  rd_en,
  output i2cbl_pkg::run_desc_t  rd_data,
  output logic                  empty
);
  import i2cbl_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  run_desc_t        slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en & ~full;
  assign do_rd   = rd_en & ~empty;
  assign rd_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// File: hw/rtl/i2cbl_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbl_back
// Result stage: expands the head run descriptor into result items, one per
// cycle while the consumer keeps popping, into an output register that the consumer pops.
// ----------------------------------------------------------------------------
module i2cbl_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  desc_valid,
  input  i2cbl_pkg::run_desc_t  desc,
  output logic                  desc_pop,
  input  logic                  out_pop,
  output logic                  out_empty,
  output logic [1:0]            out_result_kind,
  output logic [7:0]            out_tx_byte,
  output logic                  out_frame_end,
  output logic [2:0]            out_status,
  output logic [15:0]           out_product_id,
  output logic                  out_run_last
);
  import i2cbl_pkg::*;

  logic [2:0]  idx_r, idx_nxt;
  logic        valid_r, valid_nxt;
  kind_t       kind_r;
  logic [7:0]  tx_r;
  logic        fe_r;
  status_t     status_r;
  logic [15:0] pid_r;
  logic        last_r;

  logic        advance;
  logic        take;
  logic [2:0]  last_idx;
  logic        is_last;
  kind_t       kind_c;
  logic [7:0]  tx_c;
  logic        fe_c;
  logic [7:0]  addr_xor;

  assign addr_xor = desc.addr[31:24] ^ desc.addr[23:16] ^ desc.addr[15:8] ^ desc.addr[7:0];
  assign advance  = ~valid_r | out_pop;
  assign take     = advance & desc_valid;
  assign is_last  = (idx_r == last_idx);
  assign desc_pop = take & is_last;

  // result at position idx_r of the head run
  always_comb begin
    kind_c   = KIND_READ;
    tx_c     = 8'd0;
    fe_c     = 1'b0;
    last_idx = 3'd0;
    unique case (desc.run)
      RUN_CMD: begin
        last_idx = 3'd2;
        if (idx_r == 3'd0) begin
          kind_c = KIND_TX;
          tx_c   = desc.byte0;
        end else if (idx_r == 3'd1) begin
          kind_c = KIND_TX;
          tx_c   = ~desc.byte0;
          fe_c   = 1'b1;
        end
      end
      RUN_ERASE: begin
        last_idx = 3'd3;
        if (idx_r <= 3'd1) begin
          kind_c = KIND_TX;
          tx_c   = ERASE_FILL;
        end else if (idx_r == 3'd2) begin
          kind_c = KIND_TX;
          tx_c   = ERASE_END;
          fe_c   = 1'b1;
        end
      end
      RUN_ADDR: begin
        last_idx = 3'd5;
        if (idx_r != 3'd5) begin
          kind_c = KIND_TX;
        end
        unique case (idx_r)
          3'd0:    tx_c = desc.addr[31:24];
          3'd1:    tx_c = desc.addr[23:16];
          3'd2:    tx_c = desc.addr[15:8];
          3'd3:    tx_c = desc.addr[7:0];
          3'd4: begin
            tx_c = addr_xor;
            fe_c = 1'b1;
          end
          default: tx_c = 8'd0;
        endcase
      end
      RUN_TX: begin
        kind_c = KIND_TX;
        tx_c   = desc.byte0;
      end
      RUN_PAYLOAD_END: begin
        last_idx = 3'd2;
        if (idx_r == 3'd0) begin
          kind_c = KIND_TX;
          tx_c   = desc.byte0;
        end else if (idx_r == 3'd1) begin
          kind_c = KIND_TX;
          tx_c   = desc.byte1;
          fe_c   = 1'b1;
        end
      end
      RUN_READ: kind_c = KIND_READ;
      RUN_DONE: kind_c = KIND_DONE;
      default:  kind_c = KIND_READ;
    endcase
  end

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (take) begin
      idx_nxt   = is_last ? 3'd0 : idx_r + 3'd1;
      valid_nxt = 1'b1;
    end else if (out_pop) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 3'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      kind_r   <= kind_c;
      tx_r     <= tx_c;
      fe_r     <= fe_c;
      status_r <= (kind_c == KIND_DONE) ? desc.status : ST_OK;
      pid_r    <= (kind_c == KIND_DONE) ? desc.id : 16'd0;
      last_r   <= is_last;
    end
  end

  assign out_empty       = ~valid_r;
  assign out_result_kind = kind_r;
  assign out_tx_byte     = tx_r;
  assign out_frame_end   = fe_r;
  assign out_status      = status_r;
  assign out_product_id  = pid_r;
  assign out_run_last    = last_r;

endmodule

// File: hw/rtl/mcu_i2c_bootloader_host_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcu_i2c_bootloader_host_sequencer_core
// Host side of an I2C system-bootloader exchange: get id, mass erase, write
// memory and go, with checksummed frames and acknowledge waits with limits.
// ----------------------------------------------------------------------------
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------------
//  input    | push / full             | in_opcode, in_target_address,
//           |                         | in_payload_length, in_byte_value
//  result   | pop / empty             | out_result_kind, out_tx_byte, out_frame_end,
//           |                         | out_status, out_product_id, out_run_last
//  config   | psel, penable, pwrite,  | paddr (reg i at 4*i), pwdata, prdata
//           | pready (always high)    |
//
//  the sequencer takes one item per cycle while the run queue has room
//  (QUEUE_DEPTH entries); an item that causes results takes one queue entry
//  the result stage emits one result per cycle while the consumer pops; an
//  item causes 1 to 6 results, and sustained rate is set by the result count
//  reset (synchronous, rst_n low) idles the sequencer, empties the queue and
//  loads the limit registers with their defaults; no clearing pass
//  a stalled consumer holds the output register; the queue absorbs up to
//  QUEUE_DEPTH runs before full rises
//
module mcu_i2c_bootloader_host_sequencer_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // input item channel
  input  logic        push,
  output logic        full,
  input  logic [2:0]  in_opcode,
  input  logic [31:0] in_target_address,
  input  logic [8:0]  in_payload_length,
  input  logic [7:0]  in_byte_value,
  // result channel
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_result_kind,
  output logic [7:0]  out_tx_byte,
  output logic        out_frame_end,
  output logic [2:0]  out_status,
  output logic [15:0] out_product_id,
  output logic        out_run_last,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import i2cbl_pkg::*;

  ack_limits_t limits;
  run_desc_t   front_desc;
  run_desc_t   head_desc;
  logic        front_push;
  logic        queue_full;
  logic        queue_empty;
  logic        head_pop;
  logic        item_accept;

  // an item enters whenever the queue has a free entry
  assign full        = queue_full;
  assign item_accept = push & ~queue_full;

  i2cbl_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limits  (limits)
  );

  // protocol state and classification of each item
  i2cbl_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (item_accept),
    .opcode         (in_opcode),
    .target_address (in_target_address),
    .payload_length (in_payload_length),
    .byte_value     (in_byte_value),
    .limits         (limits),
    .desc_push      (front_push),
    .desc           (front_desc)
  );

  // decouples sequencing from result delivery
  i2cbl_run_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (front_push),
    .wr_data (front_desc),
    .full    (queue_full),
    .rd_en   (head_pop),
    .rd_data (head_desc),
    .empty   (queue_empty)
  );

  // expands each run into result items
  i2cbl_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .desc_valid      (~queue_empty),
    .desc            (head_desc),
    .desc_pop        (head_pop),
    .out_pop         (pop),
    .out_empty       (empty),
    .out_result_kind (out_result_kind),
    .out_tx_byte     (out_tx_byte),
    .out_frame_end   (out_frame_end),
    .out_status      (out_status),
    .out_product_id  (out_product_id),
    .out_run_last    (out_run_last)
  );

endmodule

// File: verif/tb_mcu_i2c_bootloader_host_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mcu_i2c_bootloader_host_sequencer_core
// Self-checking bench for the I2C bootloader host sequencer. A tracker class
// mirrors the exchange state, turns every accepted item into the transmit
// bytes, read requests and completions it should cause, and compares each
// popped result against the oldest one due. Directed items open the run, then
// mostly well-formed exchanges with random content under several limit
// settings and idling mixes.
// ----------------------------------------------------------------------------
module tb_mcu_i2c_bootloader_host_sequencer_core;
  import i2cbl_pkg::*;

  // busy reply is not part of the package, the sequencer treats it as any
  // other unexpected byte
  localparam logic [7:0] REPLY_BUSY = 8'h76;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES = 16;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic        fe;
    status_t     st;
    logic [15:0] pid;
    logic        last;
  } bl_result_t;

  // --------------------------------------------------------------------------
  // exchange tracker: own copy of the sequencer state and ack limits, plus the
  // results still due in the order they must come out
  // --------------------------------------------------------------------------
  class bl_exchange_tracker;
    logic [15:0] ack_limit [5];
    phase_t      ph;
    op_t         oper;
    logic [31:0] held_addr;
    logic [8:0]  left;
    logic [7:0]  xsum;
    logic [15:0] ms;
    logic [2:0]  idx;
    logic [15:0] prod_id;
    bl_result_t  due_results [$];
    int          errors;

    function void reset();
      ack_limit[REG_CMD_ACK]   = RST_CMD_ACK;
      ack_limit[REG_ADDR_ACK]  = RST_ADDR_ACK;
      ack_limit[REG_DATA_ACK]  = RST_DATA_ACK;
      ack_limit[REG_ERASE_ACK] = RST_ERASE_ACK;
      ack_limit[REG_GO_ACK]    = RST_GO_ACK;
      ph = PH_IDLE;
      oper = OP_GETID;
      held_addr = '0;
      left = '0;
      xsum = '0;
      ms = '0;
      idx = '0;
      prod_id = '0;
      errors = 0;
      due_results.delete();
    endfunction

    function void set_limit(reg_idx_t r, logic [15:0] v);
      ack_limit[r] = v;
    endfunction

    function void emit(kind_t k, logic [7:0] b, logic fe, status_t st);
      bl_result_t r;
      r.kind = k;
      r.data = b;
      r.fe = fe;
      r.st = st;
      r.pid = (k == KIND_DONE) ? prod_id : 16'h0;
      r.last = 1'b0;
      due_results.push_back(r);
    endfunction

    function void complete(status_t st);
      ph = PH_IDLE;
      emit(KIND_DONE, 8'h00, 1'b0, st);
    endfunction

    // every acknowledge wait starts with a read request and a cleared ms count
    function void await_ack(phase_t nx);
      ph = nx;
      ms = 16'h0;
      emit(KIND_READ, 8'h00, 1'b0, ST_OK);
    endfunction

    function logic [15:0] phase_limit();
      case (ph)
        PH_CMD_ACK:   return ack_limit[REG_CMD_ACK];
        PH_ADDR_ACK:  return ack_limit[REG_ADDR_ACK];
        PH_DATA_ACK:  return ack_limit[REG_DATA_ACK];
        PH_ERASE_ACK: return ack_limit[REG_ERASE_ACK];
        default:      return ack_limit[REG_GO_ACK];
      endcase
    endfunction

    function void got_ack();
      if (ph == PH_CMD_ACK) begin
        case (oper)
          OP_GETID: begin
            idx = '0;
            ph = PH_ID_REPLY;
            emit(KIND_READ, 8'h00, 1'b0, ST_OK);
          end
          OP_ERASE: begin
            emit(KIND_TX, ERASE_FILL, 1'b0, ST_OK);
            emit(KIND_TX, ERASE_FILL, 1'b0, ST_OK);
            emit(KIND_TX, ERASE_END, 1'b1, ST_OK);
            await_ack(PH_ERASE_ACK);
          end
          default: begin
            // big-endian address, then xor of its four bytes
            for (int s = 3; s >= 0; s--) emit(KIND_TX, held_addr[8*s +: 8], 1'b0, ST_OK);
            emit(KIND_TX, held_addr[31:24] ^ held_addr[23:16] ^ held_addr[15:8] ^
                 held_addr[7:0], 1'b1, ST_OK);
            await_ack(oper == OP_WRITE ? PH_ADDR_ACK : PH_GO_ACK);
          end
        endcase
      end else if (ph == PH_ADDR_ACK) begin
        // length-minus-one byte opens the payload frame
        ph = PH_PAYLOAD;
        emit(KIND_TX, xsum, 1'b0, ST_OK);
      end else begin
        complete(ST_OK);
      end
    endfunction

    function void got_target(logic [7:0] b);
      if (ph == PH_ID_REPLY) begin
        if (idx == 3'd0 && b != BYTE_ACK) begin
          complete(ST_BAD_RESP);
        end else if (idx >= 3'd4) begin
          complete(ST_OK);
        end else begin
          if (idx == 3'd2) prod_id[15:8] = b;
          if (idx == 3'd3) prod_id[7:0] = b;
          idx = idx + 3'd1;
          emit(KIND_READ, 8'h00, 1'b0, ST_OK);
        end
      end else if (b == BYTE_ACK) begin
        got_ack();
      end else if (b == BYTE_NACK) begin
        complete(ST_NACK);
      end else if (ms >= phase_limit()) begin
        complete(ST_TIMEOUT);
      end else begin
        emit(KIND_READ, 8'h00, 1'b0, ST_OK);
      end
    endfunction

    function void take_item(op_t op, logic [31:0] a, logic [8:0] l, logic [7:0] b);
      int n0;
      logic [7:0] c;
      n0 = due_results.size();
      case (op)
        OP_GETID, OP_ERASE, OP_WRITE, OP_GO: begin
          if (ph == PH_IDLE) begin
            prod_id = '0;
            oper = op;
            held_addr = a;
            if (op == OP_WRITE && (l == 9'd0 || l > MAX_PAYLOAD)) begin
              complete(ST_BAD_REQ);
            end else begin
              if (op == OP_WRITE) begin
                left = l;
                xsum = l[7:0] - 8'd1;
              end
              c = (op == OP_GETID) ? CMD_GETID : (op == OP_ERASE) ? CMD_ERASE :
                  (op == OP_WRITE) ? CMD_WRITE : CMD_GO;
              emit(KIND_TX, c, 1'b0, ST_OK);
              emit(KIND_TX, ~c, 1'b1, ST_OK);
              await_ack(PH_CMD_ACK);
            end
          end
        end
        OP_PAYLOAD: begin
          if (ph == PH_PAYLOAD) begin
            xsum = xsum ^ b;
            emit(KIND_TX, b, 1'b0, ST_OK);
            if (left != 9'd0) left = left - 9'd1;
            if (left == 9'd0) begin
              emit(KIND_TX, xsum, 1'b1, ST_OK);
              await_ack(PH_DATA_ACK);
            end
          end
        end
        OP_TARGET: begin
          if (ph != PH_IDLE && ph != PH_PAYLOAD) got_target(b);
        end
        OP_TICK: begin
          // ms count saturates, and the id reply is never timed
          if (ph != PH_IDLE && ph != PH_PAYLOAD && ph != PH_ID_REPLY && ms != 16'hFFFF)
            ms = ms + 16'd1;
        end
        default: begin
          if (ph != PH_IDLE) complete(ST_BUS_FAULT);
        end
      endcase
      if (due_results.size() > n0) due_results[due_results.size() - 1].last = 1'b1;
    endfunction

    function void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s expected %0h got %0h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void match_result(logic [1:0] k, logic [7:0] b, logic fe, logic [2:0] st,
                               logic [15:0] pid, logic last);
      bl_result_t e;
      if (due_results.size() == 0) begin
        $display("%0t: result with none due: expected nothing got kind %0h byte %0h",
                 $time, k, b);
        errors++;
        return;
      end
      e = due_results.pop_front();
      check_field("result_kind", 16'(e.kind), 16'(k));
      check_field("tx_byte", 16'(e.data), 16'(b));
      check_field("frame_end", 16'(e.fe), 16'(fe));
      check_field("status", 16'(e.st), 16'(st));
      check_field("product_id", e.pid, pid);
      check_field("run_last", 16'(e.last), 16'(last));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and the block
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [2:0]  in_opcode;
  logic [31:0] in_target_address;
  logic [8:0]  in_payload_length;
  logic [7:0]  in_byte_value;
  logic        empty;
  logic        pop;
  logic [1:0]  out_result_kind;
  logic [7:0]  out_tx_byte;
  logic        out_frame_end;
  logic [2:0]  out_status;
  logic [15:0] out_product_id;
  logic        out_run_last;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bl_exchange_tracker tracker = new();

  int quiet_cycles = 0;   // cycles since the last handshake on either side
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit want_full_write = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  mcu_i2c_bootloader_host_sequencer_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_opcode         (in_opcode),
    .in_target_address (in_target_address),
    .in_payload_length (in_payload_length),
    .in_byte_value     (in_byte_value),
    .empty             (empty),
    .pop               (pop),
    .out_result_kind   (out_result_kind),
    .out_tx_byte       (out_tx_byte),
    .out_frame_end     (out_frame_end),
    .out_status        (out_status),
    .out_product_id    (out_product_id),
    .out_run_last      (out_run_last),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // --------------------------------------------------------------------------
  // monitor: both handshakes sampled at the rising edge, before the block
  // updates its registers
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full)
        tracker.take_item(op_t'(in_opcode), in_target_address, in_payload_length,
                          in_byte_value);
      if (pop && !empty)
        tracker.match_result(out_result_kind, out_tx_byte, out_frame_end, out_status,
                             out_product_id, out_run_last);
      if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // watchdog: nothing moving for too long means the block has hung
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  // result side: pop changes on the falling edge, stalls at the phase's rate
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      pop = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------

  // one item on the input side; push stays high into the next item when no
  // gap is drawn
  task automatic send_item(op_t op, logic [31:0] a, logic [8:0] l, logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      push = 1'b0;
      @(negedge clk);
    end
    push = 1'b1;
    in_opcode = op;
    in_target_address = a;
    in_payload_length = l;
    in_byte_value = b;
    do @(posedge clk); while (full);
  endtask

  task automatic write_limit(reg_idx_t r, logic [15:0] v);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {r, 2'b00};
    pwdata = {16'h0, v};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    tracker.set_limit(r, v);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic load_limits(logic [15:0] c, logic [15:0] a, logic [15:0] d,
                             logic [15:0] e, logic [15:0] g);
    write_limit(REG_CMD_ACK, c);
    write_limit(REG_ADDR_ACK, a);
    write_limit(REG_DATA_ACK, d);
    write_limit(REG_ERASE_ACK, e);
    write_limit(REG_GO_ACK, g);
  endtask

  // stop sending and wait for every due result
  task automatic drain();
    @(negedge clk);
    push = 1'b0;
    while (tracker.due_results.size() != 0) @(negedge clk);
  endtask

  // drained and quiet, so the limit registers may be rewritten
  task automatic settle();
    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  // next item, mostly a legal step of the exchange in progress
  task automatic pick_item(output op_t op, output logic [31:0] a, output logic [8:0] l,
                           output logic [7:0] b, output bit noise);
    int pick;
    a = $urandom;
    l = 9'($urandom_range(1, 8));
    b = 8'($urandom);
    op = OP_TICK;
    noise = ($urandom_range(99) < 10);
    pick = $urandom_range(99);
    if (noise) begin
      op = op_t'($urandom_range(7));
      l = 9'($urandom_range(511));
    end else begin
      case (tracker.ph)
        PH_IDLE: begin
          op = op_t'($urandom_range(3));
          if (want_full_write || pick < 3) begin
            // longest payload, kept rare
            op = OP_WRITE;
            l = 9'(MAX_PAYLOAD);
            want_full_write = 1'b0;
          end else if (pick < 7) begin
            l = 9'd0;
          end else if (pick < 11) begin
            l = 9'($urandom_range(MAX_PAYLOAD + 1, 511));
          end
        end
        PH_PAYLOAD: op = OP_PAYLOAD;
        PH_ID_REPLY: begin
          op = OP_TARGET;
          if (tracker.idx == 3'd0 && pick < 85) b = BYTE_ACK;
        end
        default: begin
          // acknowledge wait: mostly ack, with ticks, busy, nack, random bytes and faults
          if (pick < 58) begin
            op = OP_TARGET;
            b = BYTE_ACK;
          end else if (pick < 78) begin
            op = OP_TICK;
          end else if (pick < 89) begin
            op = OP_TARGET;
            b = REPLY_BUSY;
          end else if (pick < 93) begin
            op = OP_TARGET;
            b = BYTE_NACK;
          end else if (pick < 97) begin
            op = OP_TARGET;
          end else begin
            op = OP_FAULT;
          end
        end
      endcase
    end
  endtask

  // only well-formed steps count, so noise never shortens a phase
  task automatic run_random(int count);
    op_t op;
    logic [31:0] a;
    logic [8:0] l;
    logic [7:0] b;
    bit noise;
    int k;
    k = 0;
    while (k < count) begin
      pick_item(op, a, l, b, noise);
      send_item(op, a, l, b);
      if (!noise) k++;
    end
  endtask

  task automatic run_directed();
    // out-of-place items while idle are dropped
    send_item(OP_FAULT, 32'h0, 9'd0, 8'h00);
    send_item(OP_TICK, 32'h0, 9'd0, 8'h00);
    send_item(OP_TARGET, 32'h0, 9'd0, BYTE_ACK);
    send_item(OP_PAYLOAD, 32'h0, 9'd0, 8'hFF);
    // get id with a full reply, plus a begin while busy
    send_item(OP_GETID, 32'h0, 9'd0, 8'h00);
    send_item(OP_TARGET, 32'h0, 9'd0, BYTE_ACK);
    send_item(OP_GO, 32'hFFFF_FFFF, 9'd1, 8'h00);
    send_item(OP_TARGET, 32'h0, 9'd0, BYTE_ACK);
    send_item(OP_TARGET, 32'h0, 9'd0, 8'h10);
    send_item(OP_TARGET, 32'h0, 9'd0, 8'hFF);
    send_item(OP_TARGET, 32'h0, 9'd0, 8'h00);
    send_item(OP_TARGET, 32'h0, 9'd0, 8'h55);
    // one-byte write to the top address, busy on the address, nack at the end
    send_item(OP_WRITE, 32'hFFFF_FFFF, 9'd1, 8'h00);
    send_item(OP_TARGET, 32'h0, 9'd0, BYTE_ACK);
    send_item(OP_TARGET, 32'h0, 9'd0, REPLY_BUSY);
    send_item(OP_TARGET, 32'h0, 9'd0, BYTE_ACK);
    send_item(OP_PAYLOAD, 32'h0, 9'd0, 8'hFF);
    send_item(OP_TARGET, 32'h0, 9'd0, BYTE_NACK);
    // bad write lengths
    send_item(OP_WRITE, 32'h0, 9'd0, 8'h00);
    send_item(OP_WRITE, 32'h0, 9'h1FF, 8'h00);
    // mass erase cut short by a bus fault
    send_item(OP_ERASE, 32'h0, 9'd0, 8'h00);
    send_item(OP_TARGET, 32'h0, 9'd0, BYTE_ACK);
    send_item(OP_FAULT, 32'h0, 9'd0, 8'h00);
    // go to address zero
    send_item(OP_GO, 32'h0, 9'd0, 8'h00);
    send_item(OP_TARGET, 32'h0, 9'd0, BYTE_ACK);
    send_item(OP_TARGET, 32'h0, 9'd0, BYTE_ACK);
    // get id with a bad first reply byte
    send_item(OP_GETID, 32'h0, 9'd0, 8'h00);
    send_item(OP_TARGET, 32'h0, 9'd0, BYTE_ACK);
    send_item(OP_TARGET, 32'h0, 9'd0, BYTE_NACK);
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n = 1'b0;
    push = 1'b0;
    in_opcode = '0;
    in_target_address = '0;
    in_payload_length = '0;
    in_byte_value = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    tracker.reset();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // defaults, no idling
    load_limits(RST_CMD_ACK, RST_ADDR_ACK, RST_DATA_ACK, RST_ERASE_ACK, RST_GO_ACK);
    run_directed();
    run_random(32);
    settle();

    // zero limits: the first busy times out at once; sender mostly idle
    send_idle_pct = 69;
    load_limits(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_item(OP_GO, 32'h8000_0000, 9'd0, 8'h00);
    send_item(OP_TARGET, 32'h0, 9'd0, REPLY_BUSY);
    run_random(32);
    settle();

    // largest limits, receiver mostly stalled
    send_idle_pct = 0;
    recv_stall_pct = 69;
    load_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(32);
    settle();

    // small limits reached by ticks, light idling on both sides, and one
    // pause until the result side has caught up
    send_idle_pct = 13;
    recv_stall_pct = 13;
    load_limits(16'd1, 16'd2, 16'd3, 16'd4, 16'd1);
    run_random(16);
    drain();
    run_random(16);
    settle();

    // full-length write somewhere in here, no idling
    send_idle_pct = 0;
    recv_stall_pct = 0;
    load_limits(16'd2, 16'd1, 16'd3, 16'd2, 16'd5);
    want_full_write = 1'b1;
    run_random(32);
    settle();

    repeat (20) @(posedge clk);
    if (tracker.due_results.size() != 0) begin
      $display("%0t: %0d due results never came out", $time, tracker.due_results.size());
      tracker.errors++;
    end
    if (tracker.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
